// ----- src/swrr_pkg.sv -----
`default_nettype none

package swrr_pkg;

  // field and register widths
  localparam int TAG_W       = 8;
  localparam int SEL_W       = 3;
  localparam int COUNT_W     = 4;
  localparam int TABLE_W     = 64;
  localparam int LANE_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = TABLE_W;

  // running weight: 13-bit two's complement, sums held in 15 bits
  localparam int RW_W        = 13;
  localparam int SUM_W       = 15;
  localparam int RW_MAX      = 4095;
  localparam int RW_MIN      = -4096;
  localparam int NO_PICK     = -1;

  localparam int DEF_MAX_ENDPOINTS = 8;
  localparam int DEF_WEIGHT_BITS   = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_COUNT = 2'd0,
    REG_WEIGHT_TABLE = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } swrr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic out_free;
  } swrr_stat_t;

  // clamp to the signed running weight range
  function automatic logic signed [RW_W-1:0] sat_rw(input logic signed [SUM_W-1:0] v);
    logic signed [RW_W-1:0] r;
    if (v > RW_MAX) begin
      r = RW_W'(RW_MAX);
    end else if (v < RW_MIN) begin
      r = RW_W'(RW_MIN);
    end else begin
      r = RW_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/swrr_ctrl.sv -----
`default_nettype none

module swrr_ctrl
  import swrr_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  swrr_stat_t stat_i,
  output swrr_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.count_zero ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          if (in_valid_i) begin
            state_d = stat_i.count_zero ? ST_DONE : ST_SCAN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_DONE: begin
        in_ready     = stat_i.out_free;
        cmd_o.finish = stat_i.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd_o.start = in_valid_i && in_ready;
    in_stall_o  = !in_ready;
  end

endmodule

`default_nettype wire

// ----- src/swrr_datapath.sv -----
`default_nettype none

module swrr_datapath
  import swrr_pkg::*;
#(
  parameter int MAX_ENDPOINTS = DEF_MAX_ENDPOINTS,
  parameter int WEIGHT_BITS   = DEF_WEIGHT_BITS
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire  [TAG_W-1:0]       tag_i,
  input  wire                    out_stall_i,
  input  swrr_cmd_t              cmd_i,
  output swrr_stat_t             stat_o,
  output logic                   out_valid_o,
  output logic [SEL_W-1:0]       pick_index_o,
  output logic                   status_o,
  output logic [TAG_W-1:0]       tag_out_o
);

  localparam int IDX_W = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
  localparam int CNT_W = $clog2(MAX_ENDPOINTS + 1);
  localparam int TOT_W = WEIGHT_BITS + CNT_W;
  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_ENDPOINTS);

  // configuration
  logic [COUNT_W-1:0]     active_count_q;
  logic [TABLE_W-1:0]     weight_table_q;
  logic                   cfg_clear;

  // per-request working registers
  logic [IDX_W-1:0]       k_q;
  logic [IDX_W-1:0]       pick_q;
  logic [CNT_W-1:0]       n_q;
  logic [TOT_W-1:0]       total_q;
  logic signed [RW_W-1:0] best_q;
  logic [TAG_W-1:0]       tag_q;
  logic signed [RW_W-1:0] rw_q [MAX_ENDPOINTS];

  logic [CNT_W-1:0]       eff_n;
  logic [LANE_W-1:0]      lane;
  logic [WEIGHT_BITS-1:0] weight_cur;
  logic signed [RW_W-1:0] rw_cur;
  logic signed [RW_W-1:0] rw_add;
  logic signed [RW_W-1:0] rw_sub;
  logic                   pick_ok;
  logic                   better;

  assign cfg_clear = cfg_we_i && ((cfg_index_i == REG_ACTIVE_COUNT) ||
                                  (cfg_index_i == REG_WEIGHT_TABLE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= '0;
      weight_table_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_ACTIVE_COUNT) begin
        active_count_q <= cfg_data_i[COUNT_W-1:0];
      end
      if (cfg_index_i == REG_WEIGHT_TABLE) begin
        weight_table_q <= cfg_data_i[TABLE_W-1:0];
      end
    end
  end

  assign eff_n = (active_count_q > MAX_CNT) ? CNT_W'(MAX_ENDPOINTS)
                                            : active_count_q[CNT_W-1:0];

  assign lane       = weight_table_q[int'(k_q) * LANE_W +: LANE_W];
  assign weight_cur = lane[WEIGHT_BITS-1:0];
  assign rw_cur     = rw_q[k_q];
  assign rw_add     = sat_rw(SUM_W'(rw_cur) + $signed(SUM_W'(weight_cur)));
  assign rw_sub     = sat_rw(SUM_W'(best_q) - $signed(SUM_W'(total_q)));
  assign better     = rw_add > best_q;
  // best starts below zero and only grows on a pick
  assign pick_ok    = !best_q[RW_W-1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      k_q     <= '0;
      pick_q  <= '0;
      n_q     <= eff_n;
      total_q <= '0;
      best_q  <= RW_W'(NO_PICK);
      tag_q   <= tag_i;
    end else if (cmd_i.scan) begin
      k_q     <= k_q + IDX_W'(1);
      total_q <= total_q + TOT_W'(weight_cur);
      if (better) begin
        best_q <= rw_add;
        pick_q <= k_q;
      end
    end
  end

  // running weights
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ENDPOINTS; i++) begin
        rw_q[i] <= '0;
      end
    end else if (cfg_clear) begin
      for (int i = 0; i < MAX_ENDPOINTS; i++) begin
        rw_q[i] <= '0;
      end
    end else if (cmd_i.scan) begin
      rw_q[k_q] <= rw_add;
    end else if (cmd_i.finish && pick_ok) begin
      rw_q[pick_q] <= rw_sub;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      pick_index_o <= pick_ok ? SEL_W'(pick_q) : '0;
      status_o     <= !pick_ok;
      tag_out_o    <= tag_q;
    end
  end

  always_comb begin
    stat_o.count_zero = (eff_n == '0);
    stat_o.scan_last  = (CNT_W'(k_q) == (n_q - CNT_W'(1)));
    stat_o.out_free   = !out_valid_o || !out_stall_i;
  end

endmodule

`default_nettype wire

// ----- src/smooth_weighted_round_robin_top.sv -----
// Smooth weighted round-robin picker over up to MAX_ENDPOINTS endpoints.
// Each request beat adds every active endpoint's weight to its running weight,
// picks the largest running weight (lowest index on a tie) and takes the total
// of the active weights off the winner. Register 0 sets the active count
// (values above MAX_ENDPOINTS act as MAX_ENDPOINTS), register 1 holds eight
// 8-bit weights, entry k in bits 8k+7..8k; writing either one zeroes all
// running weights. With no active endpoint the result has status 1, index 0
// and the state stays as it was. A request for n active endpoints scans
// each entry in turn through the shared add/compare unit, then does one
// write-back step, during which the next request beat is already accepted
// when the output is free. A result beat sits in an output register, so a
// stalled output only holds the block at write-back.
`default_nettype none

module smooth_weighted_round_robin_top
  import swrr_pkg::*;
#(
  parameter int MAX_ENDPOINTS = DEF_MAX_ENDPOINTS,
  parameter int WEIGHT_BITS   = DEF_WEIGHT_BITS
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // configuration writes
  input  wire                   cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [CFG_DATA_W-1:0] cfg_data_i,
  // request channel
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire  [TAG_W-1:0]      tag_i,
  // result channel
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic [SEL_W-1:0]      pick_index_o,
  output logic                  status_o,
  output logic [TAG_W-1:0]      tag_out_o
);

  swrr_cmd_t  cmd;
  swrr_stat_t stat;

  // sequencing: idle, one scan step per entry, write-back
  swrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // registers, running weights, add/compare unit and output register
  swrr_datapath #(
    .MAX_ENDPOINTS (MAX_ENDPOINTS),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .tag_i        (tag_i),
    .out_stall_i  (out_stall_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .pick_index_o (pick_index_o),
    .status_o     (status_o),
    .tag_out_o    (tag_out_o)
  );

  // write-back never overruns a result beat still waiting at the output
  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_valid_o || !out_stall_i))
    else $error("write-back while output beat still pending");

  // scan step and write-back are exclusive
  a_scan_finish_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.scan, cmd.finish}))
    else $error("scan and write-back in the same cycle");

  // an empty result carries index zero
  a_empty_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (pick_index_o == '0))
    else $error("empty-set result with nonzero index");

  // a finished item always shows a result beat in the next cycle
  a_finish_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o)
    else $error("write-back without result beat");

endmodule

`default_nettype wire
